// ===== src/list_index_expression_parser_macros.svh =====
// ---------------------------------------------------------------------------
// list_index_expression_parser_macros.svh
// Assertion macros used by the checker file of the index parser.
// ---------------------------------------------------------------------------
`ifndef LIST_INDEX_EXPRESSION_PARSER_MACROS_SVH
`define LIST_INDEX_EXPRESSION_PARSER_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define LIEP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A stalled signal holds until the handshake completes.
`define LIEP_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && !(rdy)) |=> $stable(sig)) else $error(msg);

`endif

// ===== src/liep_pkg.sv =====
// ---------------------------------------------------------------------------
// liep_pkg
// Character codes, limits and status codes of the list index parser.
// ---------------------------------------------------------------------------
package liep_pkg;

    localparam int VALUE_W  = 64;
    localparam int LENGTH_W = 32;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;

    localparam logic [CHAR_W-1:0] CH_E     = 8'h65;
    localparam logic [CHAR_W-1:0] CH_N     = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    // Largest magnitude that may still take another digit: (INT64_MAX - d) / 10
    localparam logic [VALUE_W-1:0] DIGIT_LIMIT_HI = 64'd922337203685477580; // d <= 7
    localparam logic [VALUE_W-1:0] DIGIT_LIMIT_LO = 64'd922337203685477579; // d  > 7
    localparam logic [3:0]         DIGIT_SPLIT    = 4'd7;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SYNTAX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVF    = 2'd2;

endpackage

// ===== src/liep_ifs.sv =====
// ---------------------------------------------------------------------------
// liep_ifs
// Valid/ready channels of the list index parser: characters, results, config.
// ---------------------------------------------------------------------------
interface liep_char_if;
    logic                         valid;
    logic                         ready;
    logic [liep_pkg::CHAR_W-1:0]  ch;
    logic                         no_char;
    logic                         last;

    modport source (output valid, ch, no_char, last, input ready);
    modport sink   (input valid, ch, no_char, last, output ready);
endinterface

interface liep_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [liep_pkg::VALUE_W-1:0] index_value;
    logic [liep_pkg::STATUS_W-1:0]       status;

    modport source (output valid, index_value, status, input ready);
    modport sink   (input valid, index_value, status, output ready);
endinterface

interface liep_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [liep_pkg::LENGTH_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== src/list_index_expression_parser.sv =====
// ---------------------------------------------------------------------------
// list_index_expression_parser
// Streaming parser for list index strings ("end" or integer, then +/- terms).
// ---------------------------------------------------------------------------
// Usage:
//   chars  : one word per character (ch, no_char, last). The word with last
//            set closes the string and yields exactly one word on result.
//   result : index_value (signed 64 bit, zero unless status is ok) and
//            status (ok, bad syntax, overflow).
//   cfg    : write of list_length; always ready, write only while idle.
// Throughput: one character per cycle while no closing word waits for the
//   occupied fold stage; the parse step does one multiply-by-ten accumulate per digit.
// Path: a closing word passes the input register, the parse stage and the
//   fold stage into the result register.
// Reset: parse state returns to start of string, list_length clears to 0,
//   all stages are empty.
// Stall: a waiting result holds; characters keep being taken until the
//   next closing word would need the occupied fold stage.
// ---------------------------------------------------------------------------
module list_index_expression_parser
(
    input  logic               clk,
    input  logic               rst_n,
    liep_char_if.sink          chars,
    liep_result_if.source      result,
    liep_cfg_if.sink           cfg
);

    typedef enum logic [7:0]
    {
        PH_START  = 8'b0000_0001,
        PH_E      = 8'b0000_0010,
        PH_EN     = 8'b0000_0100,
        PH_SIGN   = 8'b0000_1000,
        PH_DIGITS = 8'b0001_0000,
        PH_AFTEND = 8'b0010_0000,
        PH_OP     = 8'b0100_0000,
        PH_ERR    = 8'b1000_0000
    } phase_t;

    typedef enum logic [1:0]
    {
        K_FOLD,
        K_PLAIN,
        K_SYNTAX
    } close_kind_t;

    typedef struct packed
    {
        logic [liep_pkg::VALUE_W-1:0] sum;
        logic                         ovf;
    } fold_t;

    // base +/- (signed term) with signed 64-bit overflow detection, one adder
    function automatic fold_t fold_calc(
        input logic [liep_pkg::VALUE_W-1:0] a,
        input logic [liep_pkg::VALUE_W-1:0] mag,
        input logic                         neg,
        input logic                         sub
    );
        fold_t                        f;
        logic                         do_add;
        logic                         t_msb;
        logic [liep_pkg::VALUE_W-1:0] opnd;
        do_add = (sub == neg);
        t_msb  = neg ? (~mag[liep_pkg::VALUE_W-1] ^ (mag[liep_pkg::VALUE_W-2:0] == '0))
                     : mag[liep_pkg::VALUE_W-1];
        opnd   = do_add ? mag : ~mag;
        f.sum  = a + opnd + {{(liep_pkg::VALUE_W-1){1'b0}}, ~do_add};
        f.ovf  = ((a[liep_pkg::VALUE_W-1] ^ t_msb) == sub)
                 && (a[liep_pkg::VALUE_W-1] ^ f.sum[liep_pkg::VALUE_W-1]);
        return f;
    endfunction

    // configuration
    logic [liep_pkg::LENGTH_W-1:0] list_length_reg;
    logic [liep_pkg::VALUE_W-1:0]  end_value;

    // input register
    logic                          s0_valid_reg;
    logic [liep_pkg::CHAR_W-1:0]   s0_ch_reg;
    logic                          s0_no_char_reg;
    logic                          s0_last_reg;

    // parse state
    phase_t                        phase_reg, phase_next;
    logic [liep_pkg::VALUE_W-1:0]  base_reg, base_next;
    logic [liep_pkg::VALUE_W-1:0]  term_reg, term_next;
    logic                          neg_reg, neg_next;
    logic                          sub_reg, sub_next;
    logic                          ovf_reg, ovf_next;

    // fold stage
    logic                          fold_valid_reg;
    close_kind_t                   fold_kind_reg;
    logic [liep_pkg::VALUE_W-1:0]  fold_base_reg;
    logic [liep_pkg::VALUE_W-1:0]  fold_term_reg;
    logic                          fold_neg_reg;
    logic                          fold_sub_reg;
    logic                          fold_ovf_reg;
    close_kind_t                   kind_next;

    // result register
    logic                          res_valid_reg;
    logic [liep_pkg::VALUE_W-1:0]  res_value_reg, res_value_next;
    logic [liep_pkg::STATUS_W-1:0] res_status_reg, res_status_next;

    // handshake
    logic res_free, fold_adv, fold_free, s0_consume, s0_fire, in_fire;

    // datapath helpers
    logic                          is_digit, is_op;
    logic [3:0]                    dig_val;
    logic [liep_pkg::VALUE_W-1:0]  term_mac;
    logic                          mac_ovf;
    fold_t                         mid_fold, end_fold;

    assign res_free   = !res_valid_reg || result.ready;
    assign fold_adv   = fold_valid_reg && res_free;
    assign fold_free  = !fold_valid_reg || res_free;
    assign s0_consume = !s0_last_reg || fold_free;
    assign s0_fire    = s0_valid_reg && s0_consume;
    assign chars.ready = !s0_valid_reg || s0_consume;
    assign in_fire    = chars.valid && chars.ready;

    assign cfg.ready  = 1'b1;
    assign end_value  = {{(liep_pkg::VALUE_W-liep_pkg::LENGTH_W){1'b0}}, list_length_reg}
                        - {{(liep_pkg::VALUE_W-1){1'b0}}, 1'b1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_length_reg <= '0;
        end
        else if (cfg.valid)
        begin
            list_length_reg <= cfg.data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s0_valid_reg <= 1'b1;
        end
        else if (s0_fire)
        begin
            s0_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s0_ch_reg      <= chars.ch;
            s0_no_char_reg <= chars.no_char;
            s0_last_reg    <= chars.last;
        end
    end

    // parse step
    assign is_digit = s0_ch_reg inside {[liep_pkg::CH_ZERO:liep_pkg::CH_NINE]};
    assign is_op    = (s0_ch_reg == liep_pkg::CH_PLUS) || (s0_ch_reg == liep_pkg::CH_MINUS);
    assign dig_val  = s0_ch_reg[3:0];
    assign term_mac = (term_reg << 3) + (term_reg << 1)
                      + {{(liep_pkg::VALUE_W-4){1'b0}}, dig_val};
    assign mac_ovf  = term_reg > ((dig_val > liep_pkg::DIGIT_SPLIT) ? liep_pkg::DIGIT_LIMIT_LO
                                                                   : liep_pkg::DIGIT_LIMIT_HI);
    assign mid_fold = fold_calc(base_reg, term_reg, neg_reg, sub_reg);

    always_comb
    begin
        phase_next = phase_reg;
        base_next  = base_reg;
        term_next  = term_reg;
        neg_next   = neg_reg;
        sub_next   = sub_reg;
        ovf_next   = ovf_reg;

        if (!s0_no_char_reg)
        begin
            case (phase_reg)
                PH_START, PH_OP:
                begin
                    if (phase_reg == PH_START && s0_ch_reg == liep_pkg::CH_E)
                    begin
                        phase_next = PH_E;
                    end
                    else
                    begin
                        term_next = '0;
                        neg_next  = 1'b0;
                        if (s0_ch_reg == liep_pkg::CH_PLUS)
                        begin
                            phase_next = PH_SIGN;
                        end
                        else if (s0_ch_reg == liep_pkg::CH_MINUS)
                        begin
                            neg_next   = 1'b1;
                            phase_next = PH_SIGN;
                        end
                        else if (is_digit)
                        begin
                            term_next  = {{(liep_pkg::VALUE_W-4){1'b0}}, dig_val};
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = PH_ERR;
                        end
                    end
                end
                PH_E:
                begin
                    phase_next = (s0_ch_reg == liep_pkg::CH_N) ? PH_EN : PH_ERR;
                end
                PH_EN:
                begin
                    if (s0_ch_reg == liep_pkg::CH_D)
                    begin
                        base_next  = end_value;
                        phase_next = PH_AFTEND;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                    end
                end
                PH_SIGN:
                begin
                    if (is_digit)
                    begin
                        term_next  = term_mac;
                        ovf_next   = ovf_reg | mac_ovf;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                    end
                end
                PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        term_next = term_mac;
                        ovf_next  = ovf_reg | mac_ovf;
                    end
                    else if (is_op)
                    begin
                        base_next  = mid_fold.sum;
                        ovf_next   = ovf_reg | mid_fold.ovf;
                        term_next  = '0;
                        neg_next   = 1'b0;
                        sub_next   = (s0_ch_reg == liep_pkg::CH_MINUS);
                        phase_next = PH_OP;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                    end
                end
                PH_AFTEND:
                begin
                    if (is_op)
                    begin
                        sub_next   = (s0_ch_reg == liep_pkg::CH_MINUS);
                        phase_next = PH_OP;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                    end
                end
                default:
                begin
                    phase_next = PH_ERR;
                end
            endcase
        end

        if (phase_next == PH_DIGITS)
        begin
            kind_next = K_FOLD;
        end
        else if (phase_next == PH_AFTEND)
        begin
            kind_next = K_PLAIN;
        end
        else
        begin
            kind_next = K_SYNTAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            base_reg  <= '0;
            term_reg  <= '0;
            neg_reg   <= 1'b0;
            sub_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else if (s0_fire)
        begin
            if (s0_last_reg)
            begin
                // string closed: start over
                phase_reg <= PH_START;
                base_reg  <= '0;
                term_reg  <= '0;
                neg_reg   <= 1'b0;
                sub_reg   <= 1'b0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                base_reg  <= base_next;
                term_reg  <= term_next;
                neg_reg   <= neg_next;
                sub_reg   <= sub_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // fold stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_valid_reg <= 1'b0;
        end
        else if (s0_fire && s0_last_reg)
        begin
            fold_valid_reg <= 1'b1;
        end
        else if (fold_adv)
        begin
            fold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_fire && s0_last_reg)
        begin
            fold_kind_reg <= kind_next;
            fold_base_reg <= base_next;
            fold_term_reg <= term_next;
            fold_neg_reg  <= neg_next;
            fold_sub_reg  <= sub_next;
            fold_ovf_reg  <= ovf_next;
        end
    end

    assign end_fold = fold_calc(fold_base_reg, fold_term_reg, fold_neg_reg, fold_sub_reg);

    always_comb
    begin
        res_value_next  = '0;
        res_status_next = liep_pkg::ST_SYNTAX;
        case (fold_kind_reg)
            K_FOLD:
            begin
                if (fold_ovf_reg || end_fold.ovf)
                begin
                    res_status_next = liep_pkg::ST_OVF;
                end
                else
                begin
                    res_status_next = liep_pkg::ST_OK;
                    res_value_next  = end_fold.sum;
                end
            end
            K_PLAIN:
            begin
                if (fold_ovf_reg)
                begin
                    res_status_next = liep_pkg::ST_OVF;
                end
                else
                begin
                    res_status_next = liep_pkg::ST_OK;
                    res_value_next  = fold_base_reg;
                end
            end
            default:
            begin
                res_status_next = liep_pkg::ST_SYNTAX;
            end
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fold_adv)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fold_adv)
        begin
            res_value_reg  <= res_value_next;
            res_status_reg <= res_status_next;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.index_value = res_value_reg;
    assign result.status      = res_status_reg;

endmodule

// ===== src/liep_checker.sv =====
// ---------------------------------------------------------------------------
// liep_checker
// Port-level checks of the list index parser, bound to the top level.
// ---------------------------------------------------------------------------
`include "list_index_expression_parser_macros.svh"

module liep_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                chars_valid,
    input logic                                chars_ready,
    input logic                                chars_last,
    input logic                                result_valid,
    input logic                                result_ready,
    input logic signed [liep_pkg::VALUE_W-1:0] result_index_value,
    input logic [liep_pkg::STATUS_W-1:0]       result_status
);

    // closing words taken but not yet answered
    logic [2:0] pending_reg;
    logic       last_in, res_out;

    assign last_in = chars_valid && chars_ready && chars_last;
    assign res_out = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {2'b00, last_in} - {2'b00, res_out};
        end
    end

    `LIEP_ASSERT(a_no_orphan_result, clk, rst_n, result_valid |-> (pending_reg != 3'd0), "result without a closed string")
    `LIEP_ASSERT(a_pending_bound, clk, rst_n, pending_reg <= 3'd3, "more closed strings in flight than stages")
    `LIEP_ASSERT(a_error_value_zero, clk, rst_n, (result_valid && (result_status != liep_pkg::ST_OK)) |-> (result_index_value == '0), "nonzero index with error status")
    `LIEP_ASSERT_HOLD(a_result_hold, clk, rst_n, result_valid, result_ready, {result_valid, result_index_value, result_status}, "stalled result changed")

endmodule

bind list_index_expression_parser liep_checker u_liep_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .chars_valid        (chars.valid),
    .chars_ready        (chars.ready),
    .chars_last         (chars.last),
    .result_valid       (result.valid),
    .result_ready       (result.ready),
    .result_index_value (result.index_value),
    .result_status      (result.status)
);

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Testbench of list_index_expression_parser. A table of index strings runs
// first, then random strings under several list lengths and handshake
// pressures. Each result is checked against the expected value in the table
// where one is given, else against a parser model held in the testbench.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                           STALL_LIMIT  = 2000;
    localparam int                           DRAIN_CYCLES = 4;
    localparam int                           PHASE_ITEMS  = 210;
    localparam logic [liep_pkg::VALUE_W-1:0] POS_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        AT_START, AT_E, AT_EN, AT_SIGN, AT_DIGITS, AT_AFTER_END, AT_OP, AT_ERROR
    } grammar_pos_t;

    typedef struct packed {
        logic signed [liep_pkg::VALUE_W-1:0] value;
        logic [liep_pkg::STATUS_W-1:0]       status;
    } index_result_t;

    typedef struct {
        string         text;
        bit            empty_tail;
        bit            gaps;
        bit            typed;
        index_result_t res;
    } index_vector_t;

    logic clk;
    logic rst_n;

    liep_char_if   chars_if ();
    liep_result_if result_if ();
    liep_cfg_if    cfg_if ();

    list_index_expression_parser u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    // Parser model state
    grammar_pos_t                  gpos;
    logic [liep_pkg::VALUE_W-1:0]  sum_acc;
    logic [liep_pkg::VALUE_W-1:0]  num_mag;
    bit                            num_neg;
    bit                            sub_pending;
    bit                            ovf_seen;
    logic [liep_pkg::LENGTH_W-1:0] list_len_model;

    index_result_t expected_indexes[$];
    index_result_t head_index;
    int            fail_count;
    int            item_count;
    int            idle_pct;
    int            stall_pct;
    int            quiet_cycles;

    index_vector_t index_table[23] = '{
        '{"",                       1, 0, 1, '{64'sd0, liep_pkg::ST_SYNTAX}},
        '{"end",                    0, 0, 1, '{-64'sd1, liep_pkg::ST_OK}},
        '{"0",                      0, 0, 1, '{64'sd0, liep_pkg::ST_OK}},
        '{"9223372036854775807",    0, 0, 1, '{64'sh7FFF_FFFF_FFFF_FFFF, liep_pkg::ST_OK}},
        '{"9223372036854775808",    0, 0, 1, '{64'sd0, liep_pkg::ST_OVF}},
        '{"-9223372036854775808",   0, 0, 1, '{64'sd0, liep_pkg::ST_OVF}},
        '{"-9223372036854775807-1", 0, 0, 0, '{64'sd0, liep_pkg::ST_OK}},
        '{"9223372036854775807+1",  0, 0, 1, '{64'sd0, liep_pkg::ST_OVF}},
        '{"9223372036854775807+1+", 0, 0, 1, '{64'sd0, liep_pkg::ST_SYNTAX}},
        '{"end-1",                  0, 0, 0, '{64'sd0, liep_pkg::ST_OK}},
        '{"end+-9",                 0, 0, 0, '{64'sd0, liep_pkg::ST_OK}},
        '{"+7--3",                  0, 0, 0, '{64'sd0, liep_pkg::ST_OK}},
        '{"-0+007",                 0, 0, 0, '{64'sd0, liep_pkg::ST_OK}},
        '{"12",                     0, 1, 0, '{64'sd0, liep_pkg::ST_OK}},
        '{"45",                     1, 0, 0, '{64'sd0, liep_pkg::ST_OK}},
        '{"end1",                   0, 0, 1, '{64'sd0, liep_pkg::ST_SYNTAX}},
        '{"en",                     0, 0, 1, '{64'sd0, liep_pkg::ST_SYNTAX}},
        '{"e",                      0, 0, 1, '{64'sd0, liep_pkg::ST_SYNTAX}},
        '{"-",                      0, 0, 1, '{64'sd0, liep_pkg::ST_SYNTAX}},
        '{"5x9",                    0, 0, 1, '{64'sd0, liep_pkg::ST_SYNTAX}},
        '{"\377+1",                 0, 0, 1, '{64'sd0, liep_pkg::ST_SYNTAX}},
        '{"end+",                   0, 0, 1, '{64'sd0, liep_pkg::ST_SYNTAX}},
        '{"3+-",                    0, 0, 1, '{64'sd0, liep_pkg::ST_SYNTAX}}
    };

    logic [liep_pkg::LENGTH_W-1:0] length_settings[8] = '{
        32'hFFFF_FFFF, 32'd1, 32'd0, 32'h8000_0000,
        32'd5, 32'hFFFF_FFFE, 32'd0, 32'hFFFF_FFFF
    };

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    function automatic bit is_decimal(logic [liep_pkg::CHAR_W-1:0] c);
        return c >= liep_pkg::CH_ZERO && c <= liep_pkg::CH_NINE;
    endfunction

    function automatic void clear_parse();
        gpos        = AT_START;
        sum_acc     = '0;
        num_mag     = '0;
        num_neg     = 1'b0;
        sub_pending = 1'b0;
        ovf_seen    = 1'b0;
    endfunction

    function automatic void accumulate_digit(logic [liep_pkg::CHAR_W-1:0] c);
        logic [liep_pkg::VALUE_W-1:0] d;
        d = {{(liep_pkg::VALUE_W-liep_pkg::CHAR_W){1'b0}}, c - liep_pkg::CH_ZERO};
        if (num_mag > (POS_MAX - d) / 64'd10)
            ovf_seen = 1'b1;
        num_mag = num_mag * 64'd10 + d;
    endfunction

    function automatic void fold_number();
        logic [liep_pkg::VALUE_W-1:0] t;
        logic [liep_pkg::VALUE_W-1:0] r;
        t = num_neg ? 64'd0 - num_mag : num_mag;
        if (sub_pending)
        begin
            r = sum_acc - t;
            if ((sum_acc[63] ^ t[63]) && (sum_acc[63] ^ r[63]))
                ovf_seen = 1'b1;
        end
        else
        begin
            r = sum_acc + t;
            if (!(sum_acc[63] ^ t[63]) && (sum_acc[63] ^ r[63]))
                ovf_seen = 1'b1;
        end
        sum_acc = r;
        num_mag = '0;
        num_neg = 1'b0;
    endfunction

    function automatic void open_number(logic [liep_pkg::CHAR_W-1:0] c);
        num_mag = '0;
        num_neg = 1'b0;
        if (c == liep_pkg::CH_PLUS)
            gpos = AT_SIGN;
        else if (c == liep_pkg::CH_MINUS)
        begin
            num_neg = 1'b1;
            gpos    = AT_SIGN;
        end
        else if (is_decimal(c))
        begin
            accumulate_digit(c);
            gpos = AT_DIGITS;
        end
        else
            gpos = AT_ERROR;
    endfunction

    function automatic void parse_char(logic [liep_pkg::CHAR_W-1:0] c);
        case (gpos)
            AT_START:
                if (c == liep_pkg::CH_E)
                    gpos = AT_E;
                else
                    open_number(c);
            AT_E:
                gpos = (c == liep_pkg::CH_N) ? AT_EN : AT_ERROR;
            AT_EN:
                if (c == liep_pkg::CH_D)
                begin
                    sum_acc = {32'd0, list_len_model} - 64'd1;
                    gpos    = AT_AFTER_END;
                end
                else
                    gpos = AT_ERROR;
            AT_SIGN:
                if (is_decimal(c))
                begin
                    accumulate_digit(c);
                    gpos = AT_DIGITS;
                end
                else
                    gpos = AT_ERROR;
            AT_DIGITS:
                if (is_decimal(c))
                    accumulate_digit(c);
                else if (c == liep_pkg::CH_PLUS || c == liep_pkg::CH_MINUS)
                begin
                    fold_number();
                    sub_pending = (c == liep_pkg::CH_MINUS);
                    gpos        = AT_OP;
                end
                else
                    gpos = AT_ERROR;
            AT_AFTER_END:
                if (c == liep_pkg::CH_PLUS || c == liep_pkg::CH_MINUS)
                begin
                    sub_pending = (c == liep_pkg::CH_MINUS);
                    gpos        = AT_OP;
                end
                else
                    gpos = AT_ERROR;
            AT_OP:
                open_number(c);
            default:
                gpos = AT_ERROR;
        endcase
    endfunction

    // Advance the model by one word; returns 1 when the word closes a string.
    function automatic bit parse_index_word(input logic [liep_pkg::CHAR_W-1:0] c,
                                            input bit nc, input bit lst,
                                            output index_result_t r);
        logic [liep_pkg::STATUS_W-1:0] st;
        r = '0;
        if (!nc)
            parse_char(c);
        if (!lst)
            return 1'b0;
        if (gpos == AT_DIGITS)
        begin
            fold_number();
            st = ovf_seen ? liep_pkg::ST_OVF : liep_pkg::ST_OK;
        end
        else if (gpos == AT_AFTER_END)
            st = ovf_seen ? liep_pkg::ST_OVF : liep_pkg::ST_OK;
        else
            st = liep_pkg::ST_SYNTAX;
        r.status = st;
        r.value  = (st == liep_pkg::ST_OK) ? sum_acc : '0;
        clear_parse();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic [liep_pkg::CHAR_W-1:0] rand_byte();
        int unsigned r;
        r = $urandom_range(255);
        return r[liep_pkg::CHAR_W-1:0];
    endfunction

    task automatic send_word(input logic [liep_pkg::CHAR_W-1:0] c, input bit nc,
                             input bit lst, input bit typed,
                             input index_result_t typed_res);
        int            gap;
        index_result_t r;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars_if.valid   <= 1'b1;
        chars_if.ch      <= c;
        chars_if.no_char <= nc;
        chars_if.last    <= lst;
        do
            @(posedge clk);
        while (!chars_if.ready);
        if (!(nc && !lst))
            item_count++;
        if (parse_index_word(c, nc, lst, r))
            expected_indexes.push_back(typed ? typed_res : r);
    endtask

    task automatic send_string(input logic [liep_pkg::CHAR_W-1:0] q[$],
                               input bit empty_tail, input int none_pct,
                               input bit typed, input index_result_t typed_res);
        for (int i = 0; i < q.size(); i++)
        begin
            if ($urandom_range(99) < none_pct)
                send_word(rand_byte(), 1'b1, 1'b0, 1'b0, '0);
            send_word(q[i], 1'b0, !empty_tail && i == q.size() - 1, typed, typed_res);
        end
        if (empty_tail || q.size() == 0)
            send_word(rand_byte(), 1'b1, 1'b1, typed, typed_res);
    endtask

    function automatic void append_text(ref logic [liep_pkg::CHAR_W-1:0] q[$],
                                        input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
    endfunction

    function automatic string number_text();
        logic [liep_pkg::VALUE_W-1:0] v;
        int                           k;
        k = $urandom_range(99);
        if (k < 60)
            v = {32'd0, $urandom_range(999)};
        else if (k < 72)
            v = {$urandom, $urandom};
        else if (k < 77)
            return {$sformatf("%0d", {$urandom, $urandom}), "9"};
        else if (k < 92)
            // straddle the top of the signed range
            v = POS_MAX - 64'd9 + {32'd0, $urandom_range(19)};
        else
            return {"00", $sformatf("%0d", $urandom_range(99))};
        return $sformatf("%0d", v);
    endfunction

    function automatic void random_sign(ref logic [liep_pkg::CHAR_W-1:0] q[$],
                                        input int pct);
        if ($urandom_range(99) < pct)
            q.push_back($urandom_range(1) ? liep_pkg::CH_MINUS : liep_pkg::CH_PLUS);
    endfunction

    task automatic build_random_string(output logic [liep_pkg::CHAR_W-1:0] q[$]);
        string alpha;
        int    k;
        int    pos;
        alpha = "end+-0123456789";
        q     = {};
        k     = $urandom_range(99);
        if (k < 8)
        begin
            repeat ($urandom_range(1, 6))
                q.push_back($urandom_range(1) ? alpha[$urandom_range(alpha.len() - 1)]
                                              : rand_byte());
            return;
        end
        if ($urandom_range(99) < 30)
            append_text(q, "end");
        else
        begin
            random_sign(q, 60);
            append_text(q, number_text());
        end
        repeat ($urandom_range(3))
        begin
            q.push_back($urandom_range(1) ? liep_pkg::CH_MINUS : liep_pkg::CH_PLUS);
            random_sign(q, 25);
            append_text(q, number_text());
        end
        if (k < 20)
        begin
            // break an otherwise well-formed string
            pos = $urandom_range(q.size() - 1);
            case ($urandom_range(2))
                0: q[pos] = rand_byte();
                1: q.insert(pos, rand_byte());
                default:
                    while (q.size() > pos)
                        void'(q.pop_back());
            endcase
        end
    endtask

    task automatic settle();
        chars_if.valid <= 1'b0;
        while (expected_indexes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [liep_pkg::LENGTH_W-1:0] v);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid   <= 1'b0;
        list_len_model  = v;
    endtask

    // ------------------------------------------------------------------
    // Result checking, receiver stalls, watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
        result_if.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_indexes.size() == 0)
            begin
                $display("%0t: unexpected result value %0d status %0d", $time,
                         result_if.index_value, result_if.status);
                fail_count++;
            end
            else
            begin
                head_index = expected_indexes.pop_front();
                if (result_if.index_value !== head_index.value)
                begin
                    $display("%0t: index_value expected %0d, got %0d", $time,
                             head_index.value, result_if.index_value);
                    fail_count++;
                end
                if (result_if.status !== head_index.status)
                begin
                    $display("%0t: status expected %0d, got %0d", $time,
                             head_index.status, result_if.status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((chars_if.valid && chars_if.ready) || (result_if.valid && result_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL list_index_expression_parser");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [liep_pkg::CHAR_W-1:0] seq[$];
        int                          phase_base;

        clk              = 1'b0;
        rst_n            = 1'b0;
        chars_if.valid   = 1'b0;
        chars_if.ch      = '0;
        chars_if.no_char = 1'b0;
        chars_if.last    = 1'b0;
        result_if.ready  = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.data      = '0;
        fail_count       = 0;
        item_count       = 0;
        idle_pct         = 0;
        stall_pct        = 0;
        quiet_cycles     = 0;
        list_len_model   = '0;
        clear_parse();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (index_table[i])
        begin
            seq = {};
            append_text(seq, index_table[i].text);
            send_string(seq, index_table[i].empty_tail, index_table[i].gaps ? 100 : 0,
                        index_table[i].typed, index_table[i].res);
        end

        for (int p = 0; p < 8; p++)
        begin
            settle();
            write_length(length_settings[p]);
            case (p % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct = 76;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 76;
                end
                default:
                begin
                    idle_pct = 26;
                    stall_pct <= 26;
                end
            endcase
            phase_base = item_count;
            while (item_count - phase_base < PHASE_ITEMS)
            begin
                build_random_string(seq);
                send_string(seq, $urandom_range(99) < 10, 5, 1'b0, '0);
            end
        end

        settle();
        if (fail_count == 0)
            $display("PASS list_index_expression_parser");
        else
            $display("FAIL list_index_expression_parser");
        $finish;
    end

endmodule
